>>> design/keypad_four_function_calculator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keypad calculator
// Shared by every module that checks its own logic. Each macro expects
// clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_TOP_DEFINES_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define KFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kfc_pkg.sv
// ---------------------------------------------------------------------------
// Keypad calculator package
// Key codes, field widths, status codes and controller/datapath structs.
// ---------------------------------------------------------------------------
package kfc_pkg;

  localparam int KEY_W     = 8;
  localparam int OUT_INT_W = 32;
  localparam int HUND_W    = 7;
  localparam int STATUS_W  = 2;

  localparam logic [KEY_W-1:0] KEY_EQ      = 8'h3D;  // '='
  localparam logic [KEY_W-1:0] KEY_CLR     = 8'h43;  // 'C'
  localparam logic [KEY_W-1:0] KEY_ADD     = 8'h2B;  // '+'
  localparam logic [KEY_W-1:0] KEY_SUB     = 8'h2D;  // '-'
  localparam logic [KEY_W-1:0] KEY_MUL     = 8'h2A;  // '*'
  localparam logic [KEY_W-1:0] KEY_DIV     = 8'h2F;  // '/'
  localparam logic [KEY_W-1:0] DIGIT_BELOW = 8'd47;
  localparam logic [KEY_W-1:0] DIGIT_ABOVE = 8'd58;
  localparam logic [KEY_W-1:0] KEY_ZERO    = 8'd48;

  localparam int HUND_SCALE = 100;
  localparam int DEC_BASE   = 10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KC_EQ,
    KC_DIGIT,
    KC_CLR,
    KC_OP
  } key_cls_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic mul_step;
    logic div_step;
    logic commit;
  } kfc_cmd_t;

  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic iter_last;
    logic out_free;
  } kfc_stat_t;

  function automatic key_cls_t kfc_key_class(input logic [KEY_W-1:0] key);
    key_cls_t c;
    if (key == KEY_EQ) c = KC_EQ;
    else if (key > DIGIT_BELOW && key < DIGIT_ABOVE) c = KC_DIGIT;
    else if (key == KEY_CLR) c = KC_CLR;
    else c = KC_OP;
    return c;
  endfunction

endpackage

>>> design/kfc_ifs.sv
// ---------------------------------------------------------------------------
// Keypad calculator channels
// Key input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface kfc_in_if import kfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kfc_out_if import kfc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     echo_char;
  logic                 clear_before;
  logic                 clear_after;
  logic                 result_valid;
  logic                 result_negative;
  logic [OUT_INT_W-1:0] result_integer;
  logic [HUND_W-1:0]    result_hundredths;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, output echo_char, output clear_before, output clear_after,
                  output result_valid, output result_negative, output result_integer,
                  output result_hundredths, output status, input ready);
  modport sink   (input valid, input echo_char, input clear_before, input clear_after,
                  input result_valid, input result_negative, input result_integer,
                  input result_hundredths, input status, output ready);
endinterface

>>> design/keypad_four_function_calculator_top.sv
// ---------------------------------------------------------------------------
// Keypad four-function calculator
// One result transaction per key transaction; signed fixed-point operands.
// ---------------------------------------------------------------------------
// A key passes through accept, decode and commit unless it applies a
// pending multiply or divide. A multiply runs the shift-add multiplier
// over all INTEGER_BITS+FRACTION_BITS multiplier bits, one bit per cycle;
// a divide by a nonzero operand runs the restoring divider for
// INTEGER_BITS+2*FRACTION_BITS quotient bits, one quotient bit per cycle.
// A new key is taken as soon as the previous one has been committed
// to the output register; commit waits while that register is still held.
module keypad_four_function_calculator_top import kfc_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int INTEGER_BITS  = 32
) (
  input logic       clk,
  input logic       rst_n,
  kfc_in_if.sink    in_ch,
  kfc_out_if.source out_ch
);

  kfc_cmd_t  cmd;
  kfc_stat_t stat;
  logic      ctl_ready;

  kfc_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = ctl_ready;

  kfc_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .INTEGER_BITS  (INTEGER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .key_code          (in_ch.key_code),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .echo_char         (out_ch.echo_char),
    .clear_before      (out_ch.clear_before),
    .clear_after       (out_ch.clear_after),
    .result_valid      (out_ch.result_valid),
    .result_negative   (out_ch.result_negative),
    .result_integer    (out_ch.result_integer),
    .result_hundredths (out_ch.result_hundredths),
    .status            (out_ch.status)
  );

endmodule

>>> design/kfc_controller.sv
// ---------------------------------------------------------------------------
// Keypad calculator controller
// Sequences one key: accept, decode, optional multiply/divide, commit.
// ---------------------------------------------------------------------------
`include "keypad_four_function_calculator_top_defines.svh"

module kfc_controller import kfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kfc_stat_t stat,
  output kfc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_COMMIT = 5'b10000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (stat.need_mul) state_nxt = S_MUL;
        else if (stat.need_div) state_nxt = S_DIV;
        else state_nxt = S_COMMIT;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.iter_last) state_nxt = S_COMMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.iter_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // hold the result until the output register can take it
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `KFC_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_r == S_DECODE, "accept did not lead to decode")
  `KFC_ASSERT_NEXT(a_mul_entry, state_r == S_DECODE && stat.need_mul, state_r == S_MUL, "multiply not started")
  `KFC_ASSERT_NEXT(a_commit_hold, state_r == S_COMMIT && !stat.out_free, state_r == S_COMMIT, "result dropped while output busy")

endmodule

>>> design/kfc_datapath.sv
// ---------------------------------------------------------------------------
// Keypad calculator datapath
// Operand state, sign-magnitude add/sub and digit entry, bit-serial
// multiplier, restoring divider and the output register.
// ---------------------------------------------------------------------------
`include "keypad_four_function_calculator_top_defines.svh"

module kfc_datapath import kfc_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int INTEGER_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kfc_cmd_t             cmd,
  output kfc_stat_t            stat,
  input  logic [KEY_W-1:0]     key_code,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [KEY_W-1:0]     echo_char,
  output logic                 clear_before,
  output logic                 clear_after,
  output logic                 result_valid,
  output logic                 result_negative,
  output logic [OUT_INT_W-1:0] result_integer,
  output logic [HUND_W-1:0]    result_hundredths,
  output logic [STATUS_W-1:0]  status
);

  localparam int TB = INTEGER_BITS + FRACTION_BITS;
  localparam int NW = TB + FRACTION_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam int DW = TB + 4;
  localparam int HW = FRACTION_BITS + HUND_W;
  localparam logic [TB-1:0] MAXV = '1;

  // operand state
  logic [KEY_W-1:0] key_r;
  logic [TB-1:0]    first_mag_r, second_mag_r;
  logic             first_neg_r;
  logic [KEY_W-1:0] pend_r;
  logic             entering_r, disp_r;
  status_t          sticky_r;

  // working result
  logic [TB-1:0] res_mag_r;
  logic          res_neg_r, res_ovf_r, res_dz_r;

  // iterative units
  logic [TB-1:0] mul_hi_r, mul_lo_r;
  logic [TB-1:0] div_rem_r;
  logic [NW-1:0] div_quo_r;
  logic [CW-1:0] cnt_r;

  // output register
  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_echo_r;
  logic                 out_cb_r, out_ca_r, out_rv_r, out_neg_r;
  logic [OUT_INT_W-1:0] out_int_r;
  logic [HUND_W-1:0]    out_hund_r;
  status_t              out_status_r;

  key_cls_t      cls;
  logic          apply, is_div, dz;
  logic [3:0]    dig;
  logic [DW-1:0] dsum;
  logic [TB-1:0] base;
  logic [TB:0]   sum;
  logic          b_neg;
  logic [TB-1:0] smp_mag;
  logic          smp_neg, smp_ovf, smp_dz;

  logic [TB:0]     msum;
  logic [TB-1:0]   mul_hi_nxt, mul_lo_nxt;
  logic [2*TB-1:0] prod;
  logic            mul_ovf;

  logic [TB:0]   trial;
  logic          ge;
  logic [TB-1:0] div_rem_nxt;
  logic [NW-1:0] div_quo_nxt;
  logic          div_ovf;

  status_t       sticky_new;
  logic [HW-1:0] hprod;

  always_comb begin
    cls    = kfc_key_class(key_r);
    apply  = (cls == KC_EQ) || (cls == KC_OP);
    is_div = apply && (pend_r == KEY_DIV);
    dz     = is_div && (second_mag_r == '0);
    stat.need_mul  = apply && (pend_r == KEY_MUL);
    stat.need_div  = is_div && !dz;
    stat.iter_last = (cnt_r == CW'(1));
    stat.out_free  = !out_valid_r || out_ready;

    // digit entry: the operand being entered is never negative
    dig  = 4'(key_r - KEY_ZERO);
    base = entering_r ? second_mag_r : first_mag_r;
    dsum = DW'(base) * DW'(DEC_BASE) + (DW'(dig) << FRACTION_BITS);

    // second operand is non-negative, so its sign comes from the operator
    b_neg = (pend_r == KEY_SUB);
    sum   = {1'b0, first_mag_r} + {1'b0, second_mag_r};

    smp_mag = first_mag_r;
    smp_neg = first_neg_r;
    smp_ovf = 1'b0;
    smp_dz  = 1'b0;
    priority if (cls == KC_DIGIT) begin
      smp_neg = 1'b0;
      if (dsum > DW'(MAXV)) begin
        smp_mag = MAXV;
        smp_ovf = 1'b1;
      end else begin
        smp_mag = dsum[TB-1:0];
      end
    end else if (apply && (pend_r == KEY_ADD || pend_r == KEY_SUB)) begin
      priority if (first_neg_r == b_neg) begin
        if (sum[TB]) begin
          smp_mag = MAXV;
          smp_ovf = 1'b1;
        end else begin
          smp_mag = sum[TB-1:0];
        end
      end else if (first_mag_r >= second_mag_r) begin
        smp_mag = first_mag_r - second_mag_r;
      end else begin
        smp_mag = second_mag_r - first_mag_r;
        smp_neg = b_neg;
      end
    end else if (dz) begin
      smp_mag = '0;
      smp_dz  = 1'b1;
    end else begin
      smp_mag = first_mag_r;
    end
    smp_neg = smp_neg && (smp_mag != '0);

    // shift-add multiplier, one multiplier bit per step
    msum       = {1'b0, mul_hi_r} + (mul_lo_r[0] ? {1'b0, first_mag_r} : '0);
    mul_hi_nxt = msum[TB:1];
    mul_lo_nxt = {msum[0], mul_lo_r[TB-1:1]};
    prod       = {mul_hi_nxt, mul_lo_nxt};
    mul_ovf    = |prod[2*TB-1:TB+FRACTION_BITS];

    // restoring divider, one quotient bit per step
    trial       = {div_rem_r, div_quo_r[NW-1]};
    ge          = trial >= {1'b0, second_mag_r};
    div_rem_nxt = ge ? TB'(trial - {1'b0, second_mag_r}) : trial[TB-1:0];
    div_quo_nxt = {div_quo_r[NW-2:0], ge};
    div_ovf     = |div_quo_nxt[NW-1:TB];

    // first error since the last clear wins
    priority if (sticky_r != ST_OK) sticky_new = sticky_r;
    else if (res_dz_r) sticky_new = ST_DIVZERO;
    else if (res_ovf_r) sticky_new = ST_OVERFLOW;
    else sticky_new = ST_OK;

    hprod = HW'(res_mag_r[FRACTION_BITS-1:0]) * HW'(HUND_SCALE);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) key_r <= key_code;

    if (cmd.decode) begin
      res_mag_r <= smp_mag;
      res_neg_r <= smp_neg;
      res_ovf_r <= smp_ovf;
      res_dz_r  <= smp_dz;
      mul_hi_r  <= '0;
      mul_lo_r  <= second_mag_r;
      div_rem_r <= '0;
      div_quo_r <= {first_mag_r, {FRACTION_BITS{1'b0}}};
      cnt_r     <= stat.need_mul ? CW'(TB) : CW'(NW);
    end else if (cmd.mul_step) begin
      mul_hi_r <= mul_hi_nxt;
      mul_lo_r <= mul_lo_nxt;
      cnt_r    <= cnt_r - CW'(1);
      if (stat.iter_last) begin
        res_mag_r <= mul_ovf ? MAXV : prod[TB+FRACTION_BITS-1:FRACTION_BITS];
        res_neg_r <= first_neg_r && (mul_ovf || prod[TB+FRACTION_BITS-1:FRACTION_BITS] != '0);
        res_ovf_r <= mul_ovf;
      end
    end else if (cmd.div_step) begin
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
      cnt_r     <= cnt_r - CW'(1);
      if (stat.iter_last) begin
        res_mag_r <= div_ovf ? MAXV : div_quo_nxt[TB-1:0];
        res_neg_r <= first_neg_r && (div_ovf || div_quo_nxt[TB-1:0] != '0);
        res_ovf_r <= div_ovf;
      end
    end

    if (cmd.commit) begin
      out_echo_r   <= key_r;
      out_cb_r     <= !disp_r;
      out_ca_r     <= (cls == KC_CLR);
      out_rv_r     <= (cls == KC_EQ);
      out_neg_r    <= (cls == KC_EQ) && res_neg_r;
      out_int_r    <= (cls == KC_EQ) ? OUT_INT_W'(res_mag_r[TB-1:FRACTION_BITS]) : '0;
      out_hund_r   <= (cls == KC_EQ) ? hprod[HW-1:FRACTION_BITS] : '0;
      out_status_r <= sticky_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_mag_r  <= '0;
      first_neg_r  <= 1'b0;
      second_mag_r <= '0;
      pend_r       <= '0;
      entering_r   <= 1'b0;
      disp_r       <= 1'b0;
      sticky_r     <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cmd.commit) begin
        unique case (cls)
          KC_EQ, KC_CLR: begin
            first_mag_r  <= '0;
            first_neg_r  <= 1'b0;
            second_mag_r <= '0;
            pend_r       <= '0;
            entering_r   <= 1'b0;
            disp_r       <= 1'b0;
            sticky_r     <= ST_OK;
          end
          KC_DIGIT: begin
            if (entering_r) second_mag_r <= res_mag_r;
            else begin
              first_mag_r <= res_mag_r;
              first_neg_r <= res_neg_r;
            end
            disp_r   <= 1'b1;
            sticky_r <= sticky_new;
          end
          KC_OP: begin
            first_mag_r  <= res_mag_r;
            first_neg_r  <= res_neg_r;
            second_mag_r <= '0;
            pend_r       <= key_r;
            entering_r   <= 1'b1;
            disp_r       <= 1'b1;
            sticky_r     <= sticky_new;
          end
          default: disp_r <= 1'b1;
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign echo_char         = out_echo_r;
  assign clear_before      = out_cb_r;
  assign clear_after       = out_ca_r;
  assign result_valid      = out_rv_r;
  assign result_negative   = out_neg_r;
  assign result_integer    = out_int_r;
  assign result_hundredths = out_hund_r;
  assign status            = out_status_r;

  `KFC_ASSERT_NOW(a_no_neg_zero, 1'b1, !(first_neg_r && first_mag_r == '0), "negative zero held")
  `KFC_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid_r, "committed transaction not presented")
  `KFC_ASSERT_NEXT(a_clear_state, cmd.commit && (cls == KC_EQ || cls == KC_CLR), sticky_r == ST_OK && !disp_r && !entering_r, "state not cleared")
  `KFC_ASSERT_NOW(a_hund_range, out_valid_r, out_hund_r < HUND_W'(HUND_SCALE), "hundredths out of range")

endmodule
